// ----- sv/rtq_pkg.sv -----
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared types and constants for the relative timer queue.
// ----------------------------------------------------------------------------
package rtq_pkg;

    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int ID_W    = 8;
    localparam int ENTRY_W = SEC_W + USEC_W + SEC_W + ID_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_INS,
        ST_SCAN,
        ST_PLACE0,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_FRONT,
        RD_LAST,
        RD_BELOW
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_NEW_ABOVE,
        WR_NEW_AT0
    } t_wr_sel;

    typedef struct packed {
        logic    load_item;
        logic    set_full;
        logic    pop;
        logic    cnt_inc;
        logic    k_init;
        logic    k_dec;
        logic    res_load;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic it_expire;
        logic rd_per_zero;
        logic scan_stop;
        logic k_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/relative_timer_queue.sv -----
// ----------------------------------------------------------------------------
// relative_timer_queue
// Sorted queue of relative timers with add, expire and periodic reload.
// A refused add or an expire on an empty queue goes straight to the result;
// an add or a periodic reload into a non-empty queue runs the slot scan,
// which moves one entry per cycle until the slot is found.
// One word in flight; the next is taken the cycle after the result loads.
// Reset empties the queue at once.
// ----------------------------------------------------------------------------
module relative_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [rtq_pkg::SEC_W-1:0]  i_delay_sec,
    input  logic [rtq_pkg::USEC_W-1:0] i_delay_usec,
    input  logic [rtq_pkg::SEC_W-1:0]  i_period_sec,
    input  logic [rtq_pkg::ID_W-1:0]   i_timer_id,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_fired,
    output logic [rtq_pkg::ID_W-1:0]   o_fired_id,
    output logic [rtq_pkg::SEC_W-1:0]  o_next_sec,
    output logic [rtq_pkg::USEC_W-1:0] o_next_usec,
    output logic                       o_queue_empty,
    output logic                       o_queue_full
);
    import rtq_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rtq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cmd_bit     (i_cmd),
        .i_delay_sec   (i_delay_sec),
        .i_delay_usec  (i_delay_usec),
        .i_period_sec  (i_period_sec),
        .i_timer_id    (i_timer_id),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_fired       (o_fired),
        .o_fired_id    (o_fired_id),
        .o_next_sec    (o_next_sec),
        .o_next_usec   (o_next_usec),
        .o_queue_empty (o_queue_empty),
        .o_queue_full  (o_queue_full)
    );

endmodule

// ----- sv/rtq_ram.sv -----
// ----------------------------------------------------------------------------
// rtq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/rtq_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtq_ctrl
// Sequencer for add, expire, sorted insert scan and result hand-off.
// ----------------------------------------------------------------------------
module rtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rtq_pkg::t_dp_sts i_sts,
    output rtq_pkg::t_dp_cmd o_cmd
);
    import rtq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.it_expire) begin
                    n_state = i_sts.cnt_zero ? ST_FINISH : ST_POP;
                end else begin
                    n_state = i_sts.cnt_full ? ST_FINISH : ST_INS;
                end
            end
            ST_POP: begin
                n_state = i_sts.rd_per_zero ? ST_FINISH : ST_INS;
            end
            ST_INS: begin
                n_state = i_sts.cnt_zero ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_stop) begin
                    n_state = ST_FINISH;
                end else if (i_sts.k_zero) begin
                    n_state = ST_PLACE0;
                end
            end
            ST_PLACE0: n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rd_sel = RD_FRONT;
        o_cmd.wr_sel = WR_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.set_full = !i_sts.it_expire && i_sts.cnt_full;
            end
            ST_POP: begin
                o_cmd.pop = 1'b1;
            end
            ST_INS: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.wr_sel  = WR_NEW_AT0;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    o_cmd.k_init = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_stop) begin
                    o_cmd.wr_sel  = WR_NEW_ABOVE;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    o_cmd.wr_sel = WR_SHIFT;
                    if (!i_sts.k_zero) begin
                        o_cmd.k_dec  = 1'b1;
                        o_cmd.rd_sel = RD_BELOW;
                    end
                end
            end
            ST_PLACE0: begin
                o_cmd.wr_sel  = WR_NEW_AT0;
                o_cmd.cnt_inc = 1'b1;
            end
            ST_FINISH: begin
            end
            ST_OUT: begin
                o_cmd.res_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/rtq_dp.sv -----
// ----------------------------------------------------------------------------
// rtq_dp
// Timer queue datapath: circular slot store with a running seconds offset,
// scan compare, pop and result registers.
// ----------------------------------------------------------------------------
module rtq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rtq_pkg::t_dp_cmd           i_cmd,
    output rtq_pkg::t_dp_sts           o_sts,
    input  logic                       i_cmd_bit,
    input  logic [rtq_pkg::SEC_W-1:0]  i_delay_sec,
    input  logic [rtq_pkg::USEC_W-1:0] i_delay_usec,
    input  logic [rtq_pkg::SEC_W-1:0]  i_period_sec,
    input  logic [rtq_pkg::ID_W-1:0]   i_timer_id,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_fired,
    output logic [rtq_pkg::ID_W-1:0]   o_fired_id,
    output logic [rtq_pkg::SEC_W-1:0]  o_next_sec,
    output logic [rtq_pkg::USEC_W-1:0] o_next_usec,
    output logic                       o_queue_empty,
    output logic                       o_queue_full
);
    import rtq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // logical slot -> RAM address, wrapping around the head
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW:0]   lg);
        logic [AW:0] sum;
        sum = {1'b0, head} + lg;
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [SEC_W-1:0]  r_off;
    logic [AW-1:0]     r_k;
    logic              r_it_expire;
    logic [SEC_W-1:0]  r_it_sec;
    logic [USEC_W-1:0] r_it_usec;
    logic [SEC_W-1:0]  r_it_per;
    logic [ID_W-1:0]   r_it_id;
    logic              r_fired;
    logic [ID_W-1:0]   r_fid;
    logic              r_full;
    logic              r_out_valid;
    logic              r_out_fired;
    logic [ID_W-1:0]   r_out_fid;
    logic [SEC_W-1:0]  r_out_sec;
    logic [USEC_W-1:0] r_out_usec;
    logic              r_out_empty;
    logic              r_out_full;

    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [SEC_W-1:0]   rd_sec;
    logic [USEC_W-1:0]  rd_usec;
    logic [SEC_W-1:0]   rd_per;
    logic [ID_W-1:0]    rd_id;
    logic [SEC_W-1:0]   rd_rel;
    logic [AW:0]        last_lg;
    logic [AW:0]        above_lg;
    logic [AW-1:0]      head_inc;
    logic               out_free;

    assign {rd_sec, rd_usec, rd_per, rd_id} = rd_data;
    assign rd_rel   = rd_sec - r_off;
    assign last_lg  = (AW+1)'(r_count - CW'(1));
    assign above_lg = {1'b0, r_k} + (AW+1)'(1);
    assign head_inc = f_phys(r_head, (AW+1)'(1));
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_LAST:  rd_addr = f_phys(r_head, last_lg);
            RD_BELOW: rd_addr = f_phys(r_head, (AW+1)'(r_k) - (AW+1)'(1));
            default:  rd_addr = r_head;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = f_phys(r_head, above_lg);
        wr_data = {r_it_sec + r_off, r_it_usec, r_it_per, r_it_id};
        unique case (i_cmd.wr_sel)
            WR_SHIFT:     wr_data = rd_data;
            WR_NEW_ABOVE: begin
            end
            WR_NEW_AT0:   wr_addr = r_head;
            default:      wr_en = 1'b0;
        endcase
    end

    rtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_head  <= head_inc;
                r_count <= r_count - CW'(1);
                r_off   <= rd_sec;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.k_init) begin
            r_k <= last_lg[AW-1:0];
        end else if (i_cmd.k_dec) begin
            r_k <= r_k - AW'(1);
        end
        if (i_cmd.load_item) begin
            r_it_expire <= i_cmd_bit;
            r_it_sec    <= i_delay_sec;
            r_it_usec   <= i_delay_usec;
            r_it_per    <= i_period_sec;
            r_it_id     <= i_timer_id;
            r_fired     <= 1'b0;
            r_fid       <= '0;
            r_full      <= 1'b0;
        end else if (i_cmd.pop) begin
            // reload entry: seconds take the period
            r_it_sec  <= rd_per;
            r_it_usec <= rd_usec;
            r_it_per  <= rd_per;
            r_it_id   <= rd_id;
            r_fired   <= 1'b1;
            r_fid     <= rd_id;
        end else if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.res_load) begin
            r_out_fired <= r_fired;
            r_out_fid   <= r_fid;
            r_out_full  <= r_full;
            r_out_empty <= (r_count == '0);
            r_out_sec   <= (r_count == '0) ? '0 : rd_rel;
            r_out_usec  <= (r_count == '0) ? '0 : rd_usec;
        end
    end

    always_comb begin
        o_sts.cnt_zero    = (r_count == '0);
        o_sts.cnt_full    = (r_count == CW'(QUEUE_DEPTH));
        o_sts.it_expire   = r_it_expire;
        o_sts.rd_per_zero = (rd_per == '0);
        o_sts.scan_stop   = (rd_rel < r_it_sec) ||
                            ((rd_rel == r_it_sec) && (rd_usec <= r_it_usec));
        o_sts.k_zero      = (r_k == '0);
        o_sts.out_free    = out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_fired       = r_out_fired;
    assign o_fired_id    = r_out_fid;
    assign o_next_sec    = r_out_sec;
    assign o_next_usec   = r_out_usec;
    assign o_queue_empty = r_out_empty;
    assign o_queue_full  = r_out_full;

endmodule
